### design/lru_pkg.sv
`timescale 1ns / 1ps

package lru_pkg;

  localparam int PAGE_BITS      = 16;
  localparam int FRAMES_DEFAULT = 4;
  localparam int CNT_BITS       = 32;

  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic                 last_ref;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [CNT_BITS-1:0]  hits_so_far;
    logic [CNT_BITS-1:0]  faults_so_far;
    logic                 last_out;
  } out_item_t;

  typedef struct packed {
    logic                 hit;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic                 last;
  } lookup_res_t;

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_BITS'(1);
  endfunction

endpackage

### design/lru_mem.sv
`timescale 1ns / 1ps

module lru_mem
  import lru_pkg::*;
#(
  parameter int  FRAMES = FRAMES_DEFAULT,
  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic                 page_we,
  input  logic                 rank_we,
  input  logic [PAGE_BITS-1:0] wr_page,
  input  logic [IDX_W-1:0]     wr_rank,
  output logic [PAGE_BITS-1:0] rd_page,
  output logic [IDX_W-1:0]     rd_rank
);

  logic [PAGE_BITS-1:0] page_mem [FRAMES];
  logic [IDX_W-1:0]     rank_mem [FRAMES];

  always_ff @(posedge clk) begin
    if (page_we) begin
      page_mem[wr_addr] <= wr_page;
    end
    if (rank_we) begin
      rank_mem[wr_addr] <= wr_rank;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_page <= page_mem[rd_addr];
      rd_rank <= rank_mem[rd_addr];
    end
  end

endmodule

### design/lru_ctrl.sv
`timescale 1ns / 1ps

module lru_ctrl
  import lru_pkg::*;
#(
  parameter int  FRAMES = FRAMES_DEFAULT,
  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_free,
  output logic                 done,
  output lookup_res_t          res,
  output logic                 rd_en,
  output logic [IDX_W-1:0]     rd_addr,
  output logic [IDX_W-1:0]     wr_addr,
  output logic                 page_we,
  output logic                 rank_we,
  output logic [PAGE_BITS-1:0] wr_page,
  output logic [IDX_W-1:0]     wr_rank,
  input  logic [PAGE_BITS-1:0] rd_page,
  input  logic [IDX_W-1:0]     rd_rank
);

  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam logic [IDX_W-1:0] LAST_RANK  = IDX_W'(FRAMES - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(FRAMES);
  localparam logic [CNT_W-1:0] LAST_LIMIT = CNT_W'(FRAMES - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_AGE  = 4'b0100,
    ST_UPD  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic                 pend_r, pend_nxt;
  logic [IDX_W-1:0]     pend_idx_r, pend_idx_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic                 last_r, last_nxt;
  logic                 hit_r, hit_nxt;
  logic [IDX_W-1:0]     hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]     hit_rank_r, hit_rank_nxt;
  logic [IDX_W-1:0]     vic_idx_r, vic_idx_nxt;
  logic [PAGE_BITS-1:0] vic_page_r, vic_page_nxt;

  logic                 full;
  logic                 more;
  logic [CNT_W-1:0]     limit;

  assign full     = (count_r == FULL_COUNT);
  assign more     = (idx_r != count_r);
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    if (hit_r) begin
      limit = CNT_W'(hit_rank_r);
    end else if (full) begin
      limit = LAST_LIMIT;
    end else begin
      limit = FULL_COUNT;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    pend_nxt     = 1'b0;
    pend_idx_nxt = pend_idx_r;
    count_nxt    = count_r;
    page_nxt     = page_r;
    last_nxt     = last_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    hit_rank_nxt = hit_rank_r;
    vic_idx_nxt  = vic_idx_r;
    vic_page_nxt = vic_page_r;

    rd_en   = 1'b0;
    rd_addr = idx_r[IDX_W-1:0];
    wr_addr = pend_idx_r;
    page_we = 1'b0;
    rank_we = 1'b0;
    wr_page = page_r;
    wr_rank = rd_rank + IDX_W'(1);

    done              = 1'b0;
    res.hit           = hit_r;
    res.evicted_valid = !hit_r && full;
    res.evicted_page  = (!hit_r && full) ? vic_page_r : '0;
    res.last          = last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          page_nxt  = in_data.page;
          last_nxt  = in_data.last_ref;
          hit_nxt   = 1'b0;
          idx_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = more;
        if (more) begin
          idx_nxt      = idx_r + CNT_W'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r[IDX_W-1:0];
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_AGE;
        end
        if (pend_r) begin
          if (rd_page == page_r) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = pend_idx_r;
            hit_rank_nxt = rd_rank;
          end
          if (rd_rank == LAST_RANK) begin
            vic_idx_nxt  = pend_idx_r;
            vic_page_nxt = rd_page;
          end
        end
      end
      ST_AGE: begin
        rd_en = more;
        if (more) begin
          idx_nxt      = idx_r + CNT_W'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r[IDX_W-1:0];
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_UPD;
        end
        if (pend_r && (CNT_W'(rd_rank) < limit)) begin
          rank_we = 1'b1;
        end
      end
      ST_UPD: begin
        wr_rank = '0;
        if (hit_r) begin
          wr_addr = hit_idx_r;
        end else if (full) begin
          wr_addr = vic_idx_r;
        end else begin
          wr_addr = count_r[IDX_W-1:0];
        end
        if (out_free) begin
          done      = 1'b1;
          rank_we   = 1'b1;
          page_we   = !hit_r;
          state_nxt = ST_IDLE;
          if (!hit_r && !full) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      pend_r  <= 1'b0;
      count_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
      count_r <= count_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    page_r     <= page_nxt;
    last_r     <= last_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_rank_r <= hit_rank_nxt;
    vic_idx_r  <= vic_idx_nxt;
    vic_page_r <= vic_page_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("resident count exceeds frame count");

  a_count_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      ($past(state_r) == ST_UPD && !$past(hit_r) && $past(out_free)))
    else $error("resident count changed outside a miss update");

  a_age_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_AGE && rank_we) |-> (CNT_W'(pend_idx_r) < count_r))
    else $error("rank aging hit an unoccupied frame");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && hit_r) |-> (CNT_W'(hit_idx_r) < count_r))
    else $error("hit frame outside resident set");

endmodule

### design/lru_page_replacement.sv
`timescale 1ns / 1ps
// Each input transaction takes one frame memory read per cycle over the R resident
// frames (R at most FRAMES), once for the lookup scan and once for the rank aging pass,
// then an update that waits for the output register; transactions do not overlap.
// The next input transaction is taken while a result waits in the output register.
// Reset (rst_n low, synchronous) empties the frame set and clears both counters.
module lru_page_replacement
  import lru_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic                 page_we;
  logic                 rank_we;
  logic [PAGE_BITS-1:0] wr_page;
  logic [IDX_W-1:0]     wr_rank;
  logic [PAGE_BITS-1:0] rd_page;
  logic [IDX_W-1:0]     rd_rank;

  logic                 done;
  lookup_res_t          res;
  logic                 out_free;

  logic                 out_valid_r;
  out_item_t            out_data_r;
  logic [CNT_BITS-1:0]  hit_total_r;
  logic [CNT_BITS-1:0]  fault_total_r;
  logic [CNT_BITS-1:0]  hits_cur;
  logic [CNT_BITS-1:0]  faults_cur;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign hits_cur   = res.hit ? sat_inc(hit_total_r) : hit_total_r;
  assign faults_cur = res.hit ? fault_total_r : sat_inc(fault_total_r);

  lru_mem #(
    .FRAMES(FRAMES)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .page_we (page_we),
    .rank_we (rank_we),
    .wr_page (wr_page),
    .wr_rank (wr_rank),
    .rd_page (rd_page),
    .rd_rank (rd_rank)
  );

  lru_ctrl #(
    .FRAMES(FRAMES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_free (out_free),
    .done     (done),
    .res      (res),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .page_we  (page_we),
    .rank_we  (rank_we),
    .wr_page  (wr_page),
    .wr_rank  (wr_rank),
    .rd_page  (rd_page),
    .rd_rank  (rd_rank)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      hit_total_r   <= '0;
      fault_total_r <= '0;
    end else begin
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (done) begin
        hit_total_r   <= res.last ? '0 : hits_cur;
        fault_total_r <= res.last ? '0 : faults_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r.hit           <= res.hit;
      out_data_r.evicted_valid <= res.evicted_valid;
      out_data_r.evicted_page  <= res.evicted_page;
      out_data_r.hits_so_far   <= hits_cur;
      out_data_r.faults_so_far <= faults_cur;
      out_data_r.last_out      <= res.last;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (done && res.last) |=> (hit_total_r == '0 && fault_total_r == '0))
    else $error("counters not cleared after final transaction");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> out_free)
    else $error("result produced while output register is occupied");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import lru_pkg::*;

  localparam int NFRAMES    = FRAMES_DEFAULT;
  localparam int QUIET_MAX  = 1000;
  localparam int CALM_TAIL  = 40;
  localparam int RAND_REFS  = 400;

  typedef struct {
    in_item_t item;
    bit       drain;
  } pend_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  pend_t     pending[$];
  out_item_t expected_q[$];

  logic [PAGE_BITS-1:0] res_page [NFRAMES];
  logic [1:0]           res_rank [NFRAMES];
  int                   occupancy;
  logic [CNT_BITS-1:0]  hit_cnt;
  logic [CNT_BITS-1:0]  fault_cnt;

  int   refs_taken   = 0;
  int   results_seen = 0;
  int   total_refs   = 0;
  int   mismatches   = 0;
  int   quiet_cycles = 0;
  int   idle_left    = 0;
  int   stall_left   = 0;
  logic calm         = 1'b0;

  lru_page_replacement DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [CNT_BITS-1:0] bump(input logic [CNT_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void age_ranks(input int limit);
    int i;
    for (i = 0; i < occupancy; i++) begin
      if (res_rank[i] < limit) res_rank[i] = res_rank[i] + 2'd1;
    end
  endfunction

  function automatic out_item_t lru_predict(input in_item_t it);
    out_item_t r;
    int        i;
    int        found;
    int        victim;
    r = '0;
    found = -1;
    for (i = 0; i < occupancy; i++) begin
      if (found < 0 && res_page[i] == it.page) found = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      age_ranks(res_rank[found]);
      res_rank[found] = '0;
      hit_cnt = bump(hit_cnt);
    end else begin
      if (occupancy < NFRAMES) begin
        age_ranks(NFRAMES);
        res_page[occupancy] = it.page;
        res_rank[occupancy] = '0;
        occupancy++;
      end else begin
        victim = 0;
        for (i = 0; i < NFRAMES; i++) begin
          if (res_rank[i] == NFRAMES - 1) victim = i;
        end
        r.evicted_valid = 1'b1;
        r.evicted_page  = res_page[victim];
        age_ranks(NFRAMES - 1);
        res_page[victim] = it.page;
        res_rank[victim] = '0;
      end
      fault_cnt = bump(fault_cnt);
    end
    r.hits_so_far   = hit_cnt;
    r.faults_so_far = fault_cnt;
    r.last_out      = it.last_ref;
    if (it.last_ref) begin
      hit_cnt   = '0;
      fault_cnt = '0;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic queue_ref(input logic [PAGE_BITS-1:0] pg, input logic last,
                           input bit drain);
    pend_t p;
    p.item.page     = pg;
    p.item.last_ref = last;
    p.drain         = drain;
    pending.push_back(p);
    total_refs++;
  endtask

  // driver
  always @(posedge clk) begin
    logic     took;
    logic     nv;
    logic     hold;
    in_item_t nd;
    pend_t    nx;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      idle_left <= 0;
      for (int i = 0; i < NFRAMES; i++) begin
        res_page[i] = '0;
        res_rank[i] = '0;
      end
      occupancy = 0;
      hit_cnt   = '0;
      fault_cnt = '0;
    end else begin
      took = in_valid && in_ready;
      nv   = in_valid;
      nd   = in_data;
      if (took) begin
        expected_q.push_back(lru_predict(in_data));
        refs_taken <= refs_taken + 1;
        nv = 1'b0;
      end
      if (!nv) begin
        hold = pending.size() == 0 ||
               (pending[0].drain && (took || refs_taken != results_seen));
        if (idle_left != 0) begin
          idle_left <= idle_left - 1;
        end else if (!hold) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            idle_left <= $urandom_range(0, 4);
          end else begin
            nx = pending.pop_front();
            nv = 1'b1;
            nd = nx.item;
          end
        end
      end
      in_valid <= nv;
      in_data  <= nd;
      calm     <= (pending.size() <= CALM_TAIL);
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $error("result with nothing pending: %p", out_data);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("hit", want.hit, out_data.hit);
          check_field("evicted_valid", want.evicted_valid, out_data.evicted_valid);
          check_field("evicted_page", want.evicted_page, out_data.evicted_page);
          check_field("hits_so_far", want.hits_so_far, out_data.hits_so_far);
          check_field("faults_so_far", want.faults_so_far, out_data.faults_so_far);
          check_field("last_out", want.last_out, out_data.last_out);
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 4);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [PAGE_BITS-1:0] pool [6];
    int                   left;
    int                   seq_len;
    int                   k;
    logic [PAGE_BITS-1:0] pg;

    // fill, hit at middle rank, hit at MRU, evictions, short sequences
    queue_ref(16'h0000, 1'b0, 1'b0);
    queue_ref(16'hFFFF, 1'b0, 1'b0);
    queue_ref(16'h0000, 1'b0, 1'b0);
    queue_ref(16'h5555, 1'b0, 1'b0);
    queue_ref(16'hAAAA, 1'b0, 1'b0);
    queue_ref(16'hAAAA, 1'b0, 1'b0);
    queue_ref(16'h1234, 1'b0, 1'b0);
    queue_ref(16'hFFFF, 1'b0, 1'b0);
    queue_ref(16'h5555, 1'b0, 1'b0);
    queue_ref(16'h1234, 1'b0, 1'b0);
    queue_ref(16'h0001, 1'b1, 1'b0);
    queue_ref(16'h5555, 1'b1, 1'b0);
    queue_ref(16'h8000, 1'b1, 1'b0);
    queue_ref(16'h7FFF, 1'b0, 1'b0);
    queue_ref(16'h7FFF, 1'b0, 1'b0);
    queue_ref(16'h8000, 1'b0, 1'b0);
    queue_ref(16'hFFFE, 1'b0, 1'b0);
    queue_ref(16'h0001, 1'b1, 1'b0);
    queue_ref(16'h00FF, 1'b0, 1'b1);
    queue_ref(16'hFF00, 1'b1, 1'b0);

    // random sequences over a small working set, with some stray pages
    for (k = 0; k < 6; k++) pool[k] = PAGE_BITS'($urandom_range(0, 16'hFFFF));
    left = RAND_REFS;
    while (left > 0) begin
      if ($urandom_range(0, 1) == 0) begin
        for (k = 0; k < 6; k++) pool[k] = PAGE_BITS'($urandom_range(0, 16'hFFFF));
      end
      seq_len = $urandom_range(1, 30);
      if (seq_len > left) seq_len = left;
      for (k = 0; k < seq_len; k++) begin
        if ($urandom_range(0, 3) == 0) pg = PAGE_BITS'($urandom_range(0, 16'hFFFF));
        else pg = pool[$urandom_range(0, 5)];
        queue_ref(pg, (k == seq_len - 1), (left == RAND_REFS / 2));
        left--;
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (refs_taken != total_refs) @(posedge clk);
    while (results_seen != refs_taken) @(posedge clk);
    repeat (30) @(posedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
